FILE: hw/rtl/mme_pkg.sv
package mme_pkg;

    localparam int MAX_DIM      = 64;
    localparam int ELEMENT_BITS = 16;
    localparam int RESULT_BITS  = 38;
    localparam int FIELD_BITS   = 6;
    localparam int DIM_BITS     = 7;
    localparam int IDX_BITS     = $clog2(MAX_DIM);
    localparam int ADDR_BITS    = 2 * IDX_BITS;
    localparam int STORE_DEPTH  = 2 ** ADDR_BITS;
    localparam int PROD_BITS    = 2 * ELEMENT_BITS;
    localparam int DIM_CAP      = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_BITS = CMD_PTR_BITS + 1;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_ROWS_A    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_COLS_B    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HOLD,
        S_ISSUE,
        S_WAIT
    } back_state_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [FIELD_BITS-1:0]   row_index;
        logic [FIELD_BITS-1:0]   col_index;
        logic signed [15:0]      element_value;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] result_value;
        logic [FIELD_BITS-1:0]         result_col;
        logic                          last_in_row;
    } out_item_t;

    typedef struct packed {
        action_t                        kind;
        logic [FIELD_BITS-1:0]          row;
        logic [FIELD_BITS-1:0]          col;
        logic signed [ELEMENT_BITS-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] inner_dim;
        logic [DIM_BITS-1:0] cols_b;
    } dims_t;

    function automatic logic [DIM_BITS-1:0] eff_dim(input logic [DIM_BITS-1:0] r);
        logic [DIM_BITS-1:0] d;
        d = r;
        if (r == '0)
        begin
            d = DIM_BITS'(1);
        end
        else if (r > DIM_BITS'(DIM_CAP))
        begin
            d = DIM_BITS'(DIM_CAP);
        end
        return d;
    endfunction

endpackage

FILE: hw/rtl/mme_ram.sv
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/mme_front.sv
module mme_front
    import mme_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  in_item_t                  in_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [DIM_BITS-1:0]       cfg_data,
    output logic                      cmd_valid,
    input  logic                      cmd_pop,
    output cmd_t                      cmd,
    output dims_t                     dims
);

    logic [DIM_BITS-1:0]     rows_a_reg;
    logic [DIM_BITS-1:0]     inner_dim_reg;
    logic [DIM_BITS-1:0]     cols_b_reg;
    cmd_t                    queue_reg [CMD_DEPTH];
    logic [CMD_PTR_BITS-1:0] wptr_reg;
    logic [CMD_PTR_BITS-1:0] rptr_reg;
    logic [CMD_CNT_BITS-1:0] count_reg;
    logic [CMD_CNT_BITS-1:0] count_next;
    logic                    accept;
    logic                    keep;
    logic                    enq;
    cmd_t                    new_cmd;

    assign cfg_ready = 1'b1;
    assign full      = (count_reg == CMD_CNT_BITS'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign accept    = push && !full;
    assign enq       = accept && keep;
    assign cmd       = queue_reg[rptr_reg];
    assign dims.inner_dim = eff_dim(inner_dim_reg);
    assign dims.cols_b    = eff_dim(cols_b_reg);

    always_comb
    begin
        keep          = 1'b0;
        new_cmd.kind  = ACT_COMPUTE;
        new_cmd.row   = in_item.row_index;
        new_cmd.col   = in_item.col_index;
        new_cmd.value = ELEMENT_BITS'(in_item.element_value);
        unique case (in_item.action) inside
            ACT_LOAD_A, ACT_LOAD_B:
            begin
                new_cmd.kind = action_t'(in_item.action);
                keep = ({1'b0, in_item.row_index} < DIM_BITS'(MAX_DIM))
                    && ({1'b0, in_item.col_index} < DIM_BITS'(MAX_DIM));
            end
            ACT_COMPUTE:
            begin
                keep = ({1'b0, in_item.row_index} < eff_dim(rows_a_reg));
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (enq && !cmd_pop)
        begin
            count_next = count_reg + CMD_CNT_BITS'(1);
        end
        else if (!enq && cmd_pop)
        begin
            count_next = count_reg - CMD_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_BITS'(64);
            inner_dim_reg <= DIM_BITS'(64);
            cols_b_reg    <= DIM_BITS'(64);
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                    CFG_INNER_DIM: inner_dim_reg <= cfg_data;
                    CFG_COLS_B:    cols_b_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            if (enq)
            begin
                wptr_reg <= wptr_reg + CMD_PTR_BITS'(1);
            end
            if (cmd_pop)
            begin
                rptr_reg <= rptr_reg + CMD_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            queue_reg[wptr_reg] <= new_cmd;
        end
    end

endmodule

FILE: hw/rtl/mme_back.sv
module mme_back
    import mme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    input  dims_t     dims,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item
);

    back_state_t                     state_reg;
    back_state_t                     state_next;
    logic [FIELD_BITS-1:0]           row_reg;
    logic [FIELD_BITS-1:0]           row_next;
    logic [FIELD_BITS-1:0]           k_reg;
    logic [FIELD_BITS-1:0]           k_next;
    logic [FIELD_BITS-1:0]           j_reg;
    logic [FIELD_BITS-1:0]           j_next;
    logic                            issue;
    logic                            acc_clear;
    logic                            k_last;
    logic                            j_last;
    logic                            rd_valid_reg;
    logic                            rd_last_reg;
    logic                            prod_valid_reg;
    logic                            prod_last_reg;
    logic signed [PROD_BITS-1:0]     prod_reg;
    logic signed [PROD_BITS-1:0]     prod_next;
    logic signed [RESULT_BITS-1:0]   acc_reg;
    logic signed [RESULT_BITS-1:0]   sum;
    logic                            out_valid_reg;
    out_item_t                       out_reg;
    logic                            we_a;
    logic                            we_b;
    logic [ADDR_BITS-1:0]            waddr;
    logic [ADDR_BITS-1:0]            raddr_a;
    logic [ADDR_BITS-1:0]            raddr_b;
    logic signed [ELEMENT_BITS-1:0]  rdata_a;
    logic signed [ELEMENT_BITS-1:0]  rdata_b;

    assign k_last  = ({1'b0, k_reg} == DIM_BITS'(dims.inner_dim - DIM_BITS'(1)));
    assign j_last  = ({1'b0, j_reg} == DIM_BITS'(dims.cols_b - DIM_BITS'(1)));
    assign waddr   = {IDX_BITS'(cmd.row), IDX_BITS'(cmd.col)};
    assign raddr_a = {IDX_BITS'(row_reg), IDX_BITS'(k_reg)};
    assign raddr_b = {IDX_BITS'(k_reg), IDX_BITS'(j_reg)};
    assign we_a    = cmd_pop && (cmd.kind == ACT_LOAD_A);
    assign we_b    = cmd_pop && (cmd.kind == ACT_LOAD_B);
    assign prod_next = rdata_a * rdata_b;
    assign sum     = acc_reg + RESULT_BITS'(prod_reg);
    assign empty   = !out_valid_reg;
    assign out_item = out_reg;

    mme_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (cmd.value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mme_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (cmd.value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        cmd_pop    = 1'b0;
        issue      = 1'b0;
        acc_clear  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == ACT_COMPUTE)
                    begin
                        row_next   = cmd.row;
                        j_next     = '0;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg)
                begin
                    k_next     = '0;
                    acc_clear  = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                issue  = 1'b1;
                k_next = k_reg + FIELD_BITS'(1);
                if (k_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (prod_valid_reg && prod_last_reg)
                begin
                    if (j_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + FIELD_BITS'(1);
                        state_next = S_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rd_valid_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_valid_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= issue;
            rd_last_reg    <= issue && k_last;
            prod_valid_reg <= rd_valid_reg;
            prod_last_reg  <= rd_last_reg;
            if (prod_valid_reg && prod_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        prod_reg <= prod_next;
        if (acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (prod_valid_reg && prod_last_reg)
        begin
            out_reg.result_value <= sum;
            out_reg.result_col   <= j_reg;
            out_reg.last_in_row  <= j_last;
        end
    end

    a_slot_free_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && prod_last_reg) |-> !out_valid_reg)
        else $error("result written over a waiting result");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE))
        else $error("command taken while busy");

    a_last_matches_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.last_in_row)
        |-> ({1'b0, out_reg.result_col} == DIM_BITS'(dims.cols_b - DIM_BITS'(1))))
        else $error("last_in_row on wrong column");

    a_product_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> ##1 prod_valid_reg)
        else $error("product lost in pipeline");

endmodule

FILE: hw/rtl/matrix_multiply_engine.sv
// Channel   Handshake            Payload
// input     push / full          in_item   (action, row_index, col_index, element_value)
// result    pop / empty          out_item  (result_value, result_col, last_in_row)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The execution unit writes each load as it takes it from the queue; a compute
// runs one column at a time: per column, inner_dim reads of one A and one B
// element, whose products pass the read and product registers into the sum.
// A four-entry command queue keeps accepting items while a row computes, until full.
// A column starts only when the result register is free, so a stalled pop
// holds the loop. Reset clears control state and the size registers to 64;
// element RAMs are not cleared.
module matrix_multiply_engine
    import mme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  in_item_t            in_item,
    output logic                empty,
    input  logic                pop,
    output out_item_t           out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [DIM_BITS-1:0] cfg_data
);

    logic  cmd_valid;
    logic  cmd_pop;
    cmd_t  cmd;
    dims_t dims;

    mme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .dims      (dims)
    );

    mme_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .dims      (dims),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item)
    );

endmodule

FILE: bench/tb_matrix_multiply_engine.sv
module tb_matrix_multiply_engine;
    import mme_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS  = 16;
    localparam int LONG_INNER   = 8;
    localparam int LONG_COLS    = 2;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    in_item_t            in_item = '0;
    logic                empty;
    logic                pop = 1'b0;
    out_item_t           out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [DIM_BITS-1:0] cfg_data = '0;

    // size registers and element stores as the block should hold them
    logic [DIM_BITS-1:0]            rows_reg = DIM_BITS'(64);
    logic [DIM_BITS-1:0]            inner_reg = DIM_BITS'(64);
    logic [DIM_BITS-1:0]            cols_reg = DIM_BITS'(64);
    logic signed [15:0]             a_elems [0:STORE_DEPTH-1];
    logic signed [15:0]             b_elems [0:STORE_DEPTH-1];
    bit                             a_loaded [0:STORE_DEPTH-1];
    bit                             b_loaded [0:STORE_DEPTH-1];

    in_item_t                       item_q [$];
    out_item_t                      product_q [$];
    int                             queued_count = 0;
    int                             accepted_count = 0;
    int                             errors = 0;
    int                             cycle_count = 0;
    int                             gap_left = 0;
    int                             hold_left = 0;
    bit                             drv_steady = 1'b0;
    bit                             mon_steady = 1'b0;

    logic signed [RESULT_BITS-1:0]  acc;
    logic signed [31:0]             prod;
    out_item_t                      exp_item;
    out_item_t                      head;

    matrix_multiply_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic int dim_used(input logic [DIM_BITS-1:0] r);
        if (r == '0)
        begin
            return 1;
        end
        if (r > DIM_BITS'(DIM_CAP))
        begin
            return DIM_CAP;
        end
        return int'(r);
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            return 0;
        end
        if (p < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int rand_elem();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0)
        begin
            return -32768;
        end
        if (p == 1)
        begin
            return 32767;
        end
        return $urandom_range(0, 65535);
    endfunction

    function automatic void queue_item(input logic [1:0] act, input int row, input int col,
                                       input int val);
        in_item_t it;
        it.action        = act;
        it.row_index     = FIELD_BITS'(row);
        it.col_index     = FIELD_BITS'(col);
        it.element_value = 16'(val);
        if (act == ACT_LOAD_A)
        begin
            a_loaded[it.row_index * MAX_DIM + it.col_index] = 1'b1;
        end
        else if (act == ACT_LOAD_B)
        begin
            b_loaded[it.row_index * MAX_DIM + it.col_index] = 1'b1;
        end
        item_q.push_back(it);
        queued_count++;
    endfunction

    // load every element that a compute of row r reads and that is still unwritten
    function automatic int load_row_inputs(input int r);
        int n;
        n = 0;
        for (int k = 0; k < dim_used(inner_reg); k++)
        begin
            if (!a_loaded[r * MAX_DIM + k])
            begin
                queue_item(ACT_LOAD_A, r, k, rand_elem());
                n++;
            end
            for (int j = 0; j < dim_used(cols_reg); j++)
            begin
                if (!b_loaded[k * MAX_DIM + j])
                begin
                    queue_item(ACT_LOAD_B, k, j, rand_elem());
                    n++;
                end
            end
        end
        return n;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROWS_A:    rows_reg = val;
            CFG_INNER_DIM: inner_reg = val;
            CFG_COLS_B:    cols_reg = val;
            default:       ;
        endcase
    endtask

    task automatic set_dims(input int rows, input int inner, input int cols);
        write_reg(CFG_ROWS_A, DIM_BITS'(rows));
        write_reg(CFG_INNER_DIM, DIM_BITS'(inner));
        write_reg(CFG_COLS_B, DIM_BITS'(cols));
    endtask

    // hold off until every transaction is accepted and every result has come back
    task automatic drain();
        while (accepted_count != queued_count || product_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int made;
        int p;
        int r;
        made = 0;
        while (made < n_items)
        begin
            p = $urandom_range(0, 99);
            if (p < 45)
            begin
                r = $urandom_range(0, dim_used(rows_reg) - 1);
                made += load_row_inputs(r);
                queue_item(ACT_COMPUTE, r, $urandom_range(0, 63), $urandom_range(0, 65535));
                made++;
            end
            else if (p < 85)
            begin
                queue_item($urandom_range(0, 1) ? ACT_LOAD_B : ACT_LOAD_A,
                           $urandom_range(0, 63), $urandom_range(0, 63), rand_elem());
                made++;
            end
            else if (p < 93)
            begin
                if (dim_used(rows_reg) < MAX_DIM)
                begin
                    queue_item(ACT_COMPUTE, $urandom_range(dim_used(rows_reg), 63),
                               $urandom_range(0, 63), $urandom_range(0, 65535));
                end
            end
            else
            begin
                queue_item(ACT_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 65535));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_dims(3, 2, 2);
        write_reg(CFG_SPARE, DIM_BITS'(85));
        queue_item(ACT_LOAD_A, 0, 0, -32768);
        queue_item(ACT_LOAD_A, 0, 1, 32767);
        queue_item(ACT_LOAD_B, 0, 0, -32768);
        queue_item(ACT_LOAD_B, 1, 0, -32768);
        queue_item(ACT_LOAD_B, 0, 1, 32767);
        queue_item(ACT_LOAD_B, 1, 1, 0);
        queue_item(ACT_COMPUTE, 0, 0, 0);
        queue_item(ACT_LOAD_A, 1, 0, 1);
        queue_item(ACT_LOAD_A, 1, 1, -1);
        queue_item(ACT_COMPUTE, 1, 63, -1);
        queue_item(ACT_COMPUTE, 3, 0, 0);
        queue_item(ACT_COMPUTE, 63, 63, 32767);
        queue_item(ACT_SPARE, 63, 63, -1);
        queue_item(ACT_LOAD_A, 63, 63, 32767);
        queue_item(ACT_LOAD_B, 63, 63, -1);
        queue_item(ACT_LOAD_A, 0, 0, 256);
        queue_item(ACT_COMPUTE, 0, 21, 12345);
        queue_item(ACT_LOAD_A, 2, 0, 32767);
        queue_item(ACT_LOAD_A, 2, 1, 32767);
        queue_item(ACT_COMPUTE, 2, 42, -12345);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       set_dims(0, 3, 2);
                1:       set_dims(100, 0, 0);
                default: set_dims($urandom_range(1, 4), $urandom_range(1, 4),
                                  $urandom_range(1, 4));
            endcase
            drv_steady = (ph % 3 == 1);
            mon_steady = (ph % 3 == 2);
            random_phase(PHASE_ITEMS);
            drain();
        end

        // long row: large positive and negative sums
        set_dims(8, LONG_INNER, LONG_COLS);
        drv_steady = 1'b1;
        mon_steady = 1'b0;
        for (int k = 0; k < LONG_INNER; k++)
        begin
            queue_item(ACT_LOAD_A, 5, k, -32768);
            for (int j = 0; j < LONG_COLS; j++)
            begin
                queue_item(ACT_LOAD_B, k, j, (j % 2 == 0) ? -32768 : 32767);
            end
        end
        queue_item(ACT_COMPUTE, 5, 0, 0);
        drain();

        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                accepted_count++;
                case (in_item.action)
                    ACT_LOAD_A:
                    begin
                        a_elems[in_item.row_index * MAX_DIM + in_item.col_index] =
                            in_item.element_value;
                    end
                    ACT_LOAD_B:
                    begin
                        b_elems[in_item.row_index * MAX_DIM + in_item.col_index] =
                            in_item.element_value;
                    end
                    ACT_COMPUTE:
                    begin
                        if (in_item.row_index < dim_used(rows_reg))
                        begin
                            for (int j = 0; j < dim_used(cols_reg); j++)
                            begin
                                acc = '0;
                                for (int k = 0; k < dim_used(inner_reg); k++)
                                begin
                                    prod = a_elems[in_item.row_index * MAX_DIM + k] *
                                           b_elems[k * MAX_DIM + j];
                                    acc += prod;
                                end
                                exp_item.result_value = acc;
                                exp_item.result_col   = FIELD_BITS'(j);
                                exp_item.last_in_row  = (j + 1 == dim_used(cols_reg));
                                product_q.push_back(exp_item);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (item_q.size() != 0)
                begin
                    in_item  <= item_q.pop_front();
                    push     <= 1'b1;
                    gap_left = drv_steady ? 0 : gap_len();
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (product_q.size() == 0)
                begin
                    $display("%0t: unexpected result: value %0d col %0d last %0b", $time,
                             out_item.result_value, out_item.result_col,
                             out_item.last_in_row);
                    errors++;
                end
                else
                begin
                    head = product_q.pop_front();
                    if (out_item.result_value !== head.result_value)
                    begin
                        $display("%0t: result_value expected %0d actual %0d", $time,
                                 head.result_value, out_item.result_value);
                        errors++;
                    end
                    if (out_item.result_col !== head.result_col)
                    begin
                        $display("%0t: result_col expected %0d actual %0d", $time,
                                 head.result_col, out_item.result_col);
                        errors++;
                    end
                    if (out_item.last_in_row !== head.last_in_row)
                    begin
                        $display("%0t: last_in_row expected %0b actual %0b", $time,
                                 head.last_in_row, out_item.last_in_row);
                        errors++;
                    end
                end
                hold_left = mon_steady ? 0 : gap_len();
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/mme_pkg.sv
hw/rtl/mme_ram.sv
hw/rtl/mme_front.sv
hw/rtl/mme_back.sv
hw/rtl/matrix_multiply_engine.sv
bench/tb_matrix_multiply_engine.sv
